// ===== rtl/pwrfd_pkg.sv =====
// Package for the pulse-width remote frame decoder: frame geometry defaults,
// register indexes, status codes and reset values of the timing registers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwrfd_pkg;

	// Default field split of one frame's data word
	localparam int ADDRESS_BITS_DEF = 8;
	localparam int COMMAND_BITS_DEF = 4;

	// Fixed field widths
	localparam int BIT_TIME_W  = 11;
	localparam int TOL_W       = 6;
	localparam int DURATION_W  = 16;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int STATUS_W    = 2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIME  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd2;

	// Register reset values
	localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST = 11'd333;
	localparam logic [TOL_W-1:0]      TOL_RST      = 6'd25;

	// Scaled bound products: (100 -/+ tol) * T
	localparam int LO_W  = 18;
	localparam int HI_W  = 19;
	localparam int CMP_W = 24;

	localparam logic [LO_W-1:0] LO_PROD_RST = LO_W'((100 - 25) * 333);
	localparam logic [HI_W-1:0] HI_PROD_RST = HI_W'((100 + 25) * 333);

endpackage

`default_nettype wire

// ===== rtl/pulse_width_remote_frame_decoder.sv =====
// Top level of the pulse-width remote frame decoder: input register, frame
// checker and result register. Depends on pwrfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One pulse (level, duration, last mark) is taken per cycle; a pulse is held in
// the input register, where it is checked against the bounds and folded into the
// frame state. The frame status is loaded into the result register when the last
// pulse leaves the input register, and the sustained rate is one pulse per cycle
// while the result side keeps up.
// The tolerance bounds are scaled products (100 -/+ tol) * T, formed on each
// configuration write and held in registers; pulses compare 100 * duration
// against them, so no division is done per pulse. A stalled result holds the
// pulse after it in the input register; further pulses are then stalled.

module pulse_width_remote_frame_decoder
	import pwrfd_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,

	input  wire                     cfg_we,
	input  wire [CFG_INDEX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]    cfg_data,

	input  wire                     pulse_valid,
	output logic                    pulse_stall,
	input  wire                     is_mark,
	input  wire [DURATION_W-1:0]    duration_us,
	input  wire                     is_last,

	output logic                    frame_valid,
	input  wire                     frame_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [ADDRESS_BITS-1:0] address,
	output logic [COMMAND_BITS-1:0] command
);

	localparam int DATA_BITS    = ADDRESS_BITS + COMMAND_BITS;
	localparam int FRAME_PULSES = 2 * DATA_BITS + 2;
	localparam int COUNT_LIMIT  = FRAME_PULSES + 1;
	localparam int CNT_W        = $clog2(COUNT_LIMIT + 1);

	localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_PULSES);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_LIMIT);
	localparam logic [CNT_W-1:0] CNT_CELLS = CNT_W'(2 * DATA_BITS);
	localparam logic [CNT_W-1:0] CNT_TRAIL = CNT_W'(2 * DATA_BITS + 1);

	// ---------------- configuration ----------------
	logic [BIT_TIME_W-1:0] bit_time_q;
	logic [TOL_W-1:0]      tol_q;
	logic [LO_W-1:0]       lo_prod_q;
	logic [HI_W-1:0]       hi_prod_q;

	logic [BIT_TIME_W-1:0] bit_time_nx;
	logic [TOL_W-1:0]      tol_nx;
	logic [LO_W-1:0]       lo_prod_nx;
	logic [HI_W-1:0]       hi_prod_nx;

	always_comb begin
		bit_time_nx = bit_time_q;
		tol_nx      = tol_q;
		case (cfg_index)
			REG_BIT_TIME:  bit_time_nx = cfg_data;
			REG_TOLERANCE: tol_nx      = cfg_data[TOL_W-1:0];
			default:       ;
		endcase
		lo_prod_nx = LO_W'((7'd100 - {1'b0, tol_nx}) * {7'd0, bit_time_nx});
		hi_prod_nx = HI_W'(({2'b0, tol_nx} + 8'd100) * {8'd0, bit_time_nx});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q <= BIT_TIME_RST;
			tol_q      <= TOL_RST;
			lo_prod_q  <= LO_PROD_RST;
			hi_prod_q  <= HI_PROD_RST;
		end else if (cfg_we) begin
			bit_time_q <= bit_time_nx;
			tol_q      <= tol_nx;
			lo_prod_q  <= lo_prod_nx;
			hi_prod_q  <= hi_prod_nx;
		end
	end

	// ---------------- input register ----------------
	logic                  valid_s1;
	logic                  mark_s1;
	logic [DURATION_W-1:0] duration_s1;
	logic                  last_s1;

	logic proceed;
	logic consume;
	logic accept;
	logic frame_valid_q;

	assign proceed     = !frame_valid_q || !frame_stall;
	assign consume     = valid_s1 && proceed;
	assign pulse_stall = valid_s1 && !proceed;
	assign accept      = pulse_valid && !pulse_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mark_s1     <= is_mark;
			duration_s1 <= duration_us;
			last_s1     <= is_last;
		end
	end

	// ---------------- pulse check ----------------
	logic [CMP_W-1:0] dur_x100;
	logic [CMP_W-1:0] dur1_x100;
	logic [CMP_W-1:0] lo1, hi1, lo2, hi2;
	logic             above1, fits1, fits2;

	// d >= floor(P/100) <=> 100*(d+1) > P ; d <= floor(P/100) <=> 100*d <= P
	always_comb begin
		dur_x100  = CMP_W'(duration_s1) * CMP_W'(100);
		dur1_x100 = dur_x100 + CMP_W'(100);
		lo1       = CMP_W'(lo_prod_q);
		hi1       = CMP_W'(hi_prod_q);
		lo2       = lo1 << 1;
		hi2       = hi1 << 1;
		above1    = dur1_x100 > lo1;
		fits1     = above1 && (dur_x100 <= hi1);
		fits2     = (dur1_x100 > lo2) && (dur_x100 <= hi2);
	end

	// ---------------- frame state ----------------
	logic [CNT_W-1:0]     count_q;
	logic [DATA_BITS-1:0] data_q;
	logic [1:0]           pend_q;
	logic                 mism_q;

	logic [CNT_W-1:0]     count_nx;
	logic [DATA_BITS-1:0] data_nx;
	logic [1:0]           pend_nx;
	logic                 mism_nx;
	logic                 cell_bit;
	logic [STATUS_W-1:0]  status_nx;

	always_comb begin
		count_nx = count_q;
		data_nx  = data_q;
		pend_nx  = pend_q;
		mism_nx  = mism_q;
		cell_bit = 1'b0;

		if (count_q == '0) begin
			// start mark
			if (!mark_s1 || !fits1)
				mism_nx = 1'b1;
		end else if (count_q <= CNT_CELLS) begin
			if (count_q[0]) begin
				// space of a bit cell: record which lengths it matched
				pend_nx = 2'b00;
				if (mark_s1)
					mism_nx = 1'b1;
				else
					pend_nx = {fits2, fits1};
			end else begin
				// mark closing the cell; long space + short mark wins ties
				if (mark_s1 && pend_q[1] && fits1)
					cell_bit = 1'b1;
				else if (!(mark_s1 && pend_q[0] && fits2))
					mism_nx = 1'b1;
				data_nx = {data_q[DATA_BITS-2:0], cell_bit};
				pend_nx = 2'b00;
			end
		end else if (count_q == CNT_TRAIL) begin
			// trailing space, open above
			if (mark_s1 || !above1)
				mism_nx = 1'b1;
		end

		if (count_q < CNT_LIMIT)
			count_nx = count_q + CNT_W'(1);

		if (count_nx != CNT_FRAME)
			status_nx = STATUS_BAD_COUNT;
		else if (mism_nx)
			status_nx = STATUS_MISMATCH;
		else
			status_nx = STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			data_q  <= '0;
			pend_q  <= 2'b00;
			mism_q  <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				count_q <= '0;
				data_q  <= '0;
				pend_q  <= 2'b00;
				mism_q  <= 1'b0;
			end else begin
				count_q <= count_nx;
				data_q  <= data_nx;
				pend_q  <= pend_nx;
				mism_q  <= mism_nx;
			end
		end
	end

	// ---------------- result register ----------------
	logic [STATUS_W-1:0]     status_q;
	logic [ADDRESS_BITS-1:0] address_q;
	logic [COMMAND_BITS-1:0] command_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			frame_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			status_q <= status_nx;
			if (status_nx == STATUS_OK) begin
				address_q <= data_nx[DATA_BITS-1:COMMAND_BITS];
				command_q <= data_nx[COMMAND_BITS-1:0];
			end else begin
				address_q <= '0;
				command_q <= '0;
			end
		end
	end

	assign frame_valid = frame_valid_q;
	assign status      = status_q;
	assign address     = address_q;
	assign command     = command_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_stall |-> valid_s1)
		else $error("pulse stalled with empty input register");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LIMIT)
		else $error("pulse count beyond its limit");

	a_pend_clear_between_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] || count_q == '0) |-> pend_q == 2'b00)
		else $error("space class left over outside a bit cell");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> (count_q == '0 && frame_valid_q))
		else $error("frame state not cleared or result missing after last pulse");

	a_fail_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid_q && status_q != STATUS_OK) |-> (address_q == '0 && command_q == '0))
		else $error("failed frame carries address or command bits");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for pulse_width_remote_frame_decoder: directed frames from a table,
// then random pulse trains over several timing settings, scored against a local decoder.
// Depends on pwrfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench
	import pwrfd_pkg::*;
();

	localparam int ADDR_W = ADDRESS_BITS_DEF;
	localparam int CMD_W = COMMAND_BITS_DEF;
	localparam int DATA_W = ADDR_W + CMD_W;
	localparam int FRAME_LEN = 2 * DATA_W + 2;
	localparam int DUR_MAX = 65535;
	localparam int PHASE_PULSES = 180;
	localparam logic [1:0] CLS_SHORT = 2'b01;
	localparam logic [1:0] CLS_LONG = 2'b10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0] address;
		logic [CMD_W-1:0] command;
	} frame_t;

	typedef enum logic [1:0] {FLT_NONE, FLT_LEVEL, FLT_TIME_LOW, FLT_TIME_HIGH} fault_t;
	typedef enum logic [2:0] {DUR_NOMINAL, DUR_LO_EDGE, DUR_HI_EDGE, DUR_SPREAD, DUR_AMBIG} style_t;

	typedef struct packed {
		logic set_timing;
		logic [BIT_TIME_W-1:0] bt;
		logic [TOL_W-1:0] tol;
		logic [DATA_W-1:0] word;
		logic [5:0] len;
		fault_t flt;
		logic [4:0] pos;
		style_t style;
		logic known;
		frame_t res;
	} dir_row_t;

	localparam frame_t NO_FRAME = '{STATUS_OK, '0, '0};
	localparam frame_t BAD_COUNT = '{STATUS_BAD_COUNT, '0, '0};
	localparam frame_t MISMATCH = '{STATUS_MISMATCH, '0, '0};

	// frame rows build a whole pulse train; timing rows reprogram the bounds
	dir_row_t dir_rows [20] = '{
		'{1'b0, 11'd0, 6'd0, 12'h000, 6'd1, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b1, BAD_COUNT},
		'{1'b0, 11'd0, 6'd0, 12'hFFF, 6'd26, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b1,
			'{STATUS_OK, 8'hFF, 4'hF}},
		'{1'b0, 11'd0, 6'd0, 12'h000, 6'd26, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b1,
			'{STATUS_OK, 8'h00, 4'h0}},
		'{1'b0, 11'd0, 6'd0, 12'hA5C, 6'd26, FLT_NONE, 5'd0, DUR_LO_EDGE, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'h35A, 6'd26, FLT_NONE, 5'd0, DUR_HI_EDGE, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'h123, 6'd25, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b1, BAD_COUNT},
		'{1'b0, 11'd0, 6'd0, 12'h456, 6'd27, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b1, BAD_COUNT},
		// long train: the count has to saturate rather than wrap back to 26
		'{1'b0, 11'd0, 6'd0, 12'h789, 6'd58, FLT_NONE, 5'd0, DUR_SPREAD, 1'b1, BAD_COUNT},
		'{1'b0, 11'd0, 6'd0, 12'hF00, 6'd26, FLT_LEVEL, 5'd0, DUR_NOMINAL, 1'b1, MISMATCH},
		'{1'b0, 11'd0, 6'd0, 12'h0F0, 6'd26, FLT_TIME_HIGH, 5'd5, DUR_NOMINAL, 1'b1, MISMATCH},
		'{1'b0, 11'd0, 6'd0, 12'h3C3, 6'd26, FLT_TIME_LOW, 5'd25, DUR_NOMINAL, 1'b1, MISMATCH},
		'{1'b0, 11'd0, 6'd0, 12'h5A5, 6'd26, FLT_LEVEL, 5'd25, DUR_NOMINAL, 1'b1, MISMATCH},
		// wrong count wins over a timing fault
		'{1'b0, 11'd0, 6'd0, 12'hABC, 6'd20, FLT_TIME_LOW, 5'd3, DUR_NOMINAL, 1'b1, BAD_COUNT},
		'{1'b0, 11'd0, 6'd0, 12'h6E1, 6'd26, FLT_LEVEL, 5'd7, DUR_NOMINAL, 1'b1, MISMATCH},
		'{1'b1, 11'd50, 6'd50, 12'h000, 6'd0, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'hF0F, 6'd26, FLT_NONE, 5'd0, DUR_AMBIG, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'h0F0, 6'd26, FLT_TIME_LOW, 5'd4, DUR_AMBIG, 1'b1, MISMATCH},
		'{1'b1, 11'd2000, 6'd0, 12'h000, 6'd0, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'hC3A, 6'd26, FLT_NONE, 5'd0, DUR_NOMINAL, 1'b0, NO_FRAME},
		'{1'b0, 11'd0, 6'd0, 12'h5C3, 6'd26, FLT_NONE, 5'd0, DUR_HI_EDGE, 1'b0, NO_FRAME}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pulse_valid = 1'b0;
	logic pulse_stall;
	logic is_mark = 1'b0;
	logic [DURATION_W-1:0] duration_us = '0;
	logic is_last = 1'b0;
	logic frame_valid;
	logic frame_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0] address;
	logic [CMD_W-1:0] command;

	// decoder mirror: timing registers and per-train state
	int unsigned bit_time = BIT_TIME_RST;
	int unsigned tol_pct = TOL_RST;
	int unsigned pulse_cnt = 0;
	logic [DATA_W-1:0] data_word = '0;
	logic [1:0] space_cls = '0;
	bit bad_timing = 1'b0;

	frame_t frames_due [$];
	int unsigned pulses_sent = 0;
	int unsigned fault_count = 0;
	int unsigned send_idle_pct = 11;
	int unsigned recv_idle_pct = 73;

	pulse_width_remote_frame_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pulse_valid(pulse_valid),
		.pulse_stall(pulse_stall),
		.is_mark(is_mark),
		.duration_us(duration_us),
		.is_last(is_last),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.status(status),
		.address(address),
		.command(command)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[pulse_width_remote_frame_decoder] ERROR");
		$finish;
	end

	function automatic int unsigned lower_lim(input int unsigned len);
		return (100 - tol_pct) * len / 100;
	endfunction

	function automatic int unsigned upper_lim(input int unsigned len);
		return (100 + tol_pct) * len / 100;
	endfunction

	function automatic bit fits(input int unsigned dur, input int unsigned len);
		return dur >= lower_lim(len) && dur <= upper_lim(len);
	endfunction

	// Folds one pulse into the train; returns 1 with the frame on the last pulse
	function automatic bit decode_pulse(input bit mark, input int unsigned dur, input bit last,
			output frame_t res);
		bit one;
		res = NO_FRAME;
		if (pulse_cnt == 0) begin
			if (!mark || !fits(dur, bit_time))
				bad_timing = 1'b1;
		end else if (pulse_cnt <= 2 * DATA_W) begin
			if (pulse_cnt % 2 == 1) begin
				space_cls = '0;
				if (mark) begin
					bad_timing = 1'b1;
				end else begin
					if (fits(dur, bit_time))
						space_cls |= CLS_SHORT;
					if (fits(dur, 2 * bit_time))
						space_cls |= CLS_LONG;
				end
			end else begin
				// an ambiguous space tries the 1 reading first
				one = 1'b0;
				if (mark && (space_cls & CLS_LONG) != 0 && fits(dur, bit_time))
					one = 1'b1;
				else if (!(mark && (space_cls & CLS_SHORT) != 0 && fits(dur, 2 * bit_time)))
					bad_timing = 1'b1;
				data_word = {data_word[DATA_W-2:0], one};
				space_cls = '0;
			end
		end else if (pulse_cnt == 2 * DATA_W + 1) begin
			if (mark || dur < lower_lim(bit_time))
				bad_timing = 1'b1;
		end
		if (pulse_cnt < FRAME_LEN + 1)
			pulse_cnt++;
		if (!last)
			return 1'b0;
		if (pulse_cnt != FRAME_LEN)
			res.status = STATUS_BAD_COUNT;
		else if (bad_timing)
			res.status = STATUS_MISMATCH;
		else
			res = '{STATUS_OK, data_word[DATA_W-1 -: ADDR_W], data_word[CMD_W-1:0]};
		pulse_cnt = 0;
		data_word = '0;
		space_cls = '0;
		bad_timing = 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_dur(input int unsigned len, input style_t style,
			input bit space);
		case (style)
			DUR_NOMINAL: return len;
			DUR_LO_EDGE: return lower_lim(len);
			DUR_HI_EDGE: return upper_lim(len);
			DUR_AMBIG: begin
				if (space && lower_lim(2 * bit_time) <= upper_lim(bit_time))
					return $urandom_range(upper_lim(bit_time), lower_lim(2 * bit_time));
			end
			default: ;
		endcase
		return $urandom_range(upper_lim(len), lower_lim(len));
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	task automatic send_pulse(input bit mark, input int unsigned dur, input bit last,
			input bit known, input frame_t typed);
		frame_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			pulse_valid <= 1'b0;
			@(posedge clk);
		end
		pulse_valid <= 1'b1;
		is_mark <= mark;
		duration_us <= DURATION_W'(dur);
		is_last <= last;
		do @(posedge clk); while (pulse_stall);
		pulses_sent++;
		if (decode_pulse(mark, dur, last, res))
			frames_due.push_back(known ? typed : res);
	endtask

	task automatic send_frame(input logic [DATA_W-1:0] word, input int unsigned len,
			input fault_t flt, input int unsigned pos, input style_t style, input bit known,
			input frame_t typed);
		bit mark;
		bit one;
		int unsigned dur;
		for (int unsigned k = 0; k < len; k++) begin
			if (k == 0) begin
				mark = 1'b1;
				dur = pick_dur(bit_time, style, 1'b0);
			end else if (k < FRAME_LEN - 1) begin
				one = word[DATA_W - 1 - (k - 1) / 2];
				mark = (k % 2 == 0);
				if (mark)
					dur = pick_dur(one ? bit_time : 2 * bit_time, style, 1'b0);
				else
					dur = pick_dur(one ? 2 * bit_time : bit_time, style, 1'b1);
			end else if (k == FRAME_LEN - 1) begin
				mark = 1'b0;
				case (style)
					DUR_NOMINAL: dur = bit_time;
					DUR_LO_EDGE: dur = lower_lim(bit_time);
					DUR_HI_EDGE: dur = DUR_MAX;
					default: begin
						if ($urandom_range(1))
							dur = $urandom_range(DUR_MAX, lower_lim(bit_time));
						else
							dur = $urandom_range(upper_lim(2 * bit_time), lower_lim(bit_time));
					end
				endcase
			end else begin
				mark = $urandom_range(1);
				dur = $urandom_range(DUR_MAX);
			end
			if (flt != FLT_NONE && k == pos) begin
				case (flt)
					FLT_LEVEL: mark = !mark;
					FLT_TIME_LOW: dur = $urandom_range(1) ? 0 :
						$urandom_range(lower_lim(bit_time) - 1, 0);
					default: dur = $urandom_range(1) ? DUR_MAX :
						$urandom_range(DUR_MAX, upper_lim(2 * bit_time) + 1);
				endcase
			end
			send_pulse(mark, dur, k == len - 1, known, typed);
		end
	endtask

	// hold off until every frame is out, then give the pipeline time to empty
	task automatic drain();
		pulse_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(input int unsigned bt, input int unsigned tol);
		cfg_we <= 1'b1;
		cfg_index <= REG_BIT_TIME;
		cfg_data <= CFG_DATA_W'(bt);
		@(posedge clk);
		cfg_index <= REG_TOLERANCE;
		cfg_data <= CFG_DATA_W'(tol);
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_time = bt;
		tol_pct = tol;
	endtask

	always @(posedge clk) begin : frame_check
		frame_t want;
		if (arst_n)
			frame_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && frame_valid && !frame_stall) begin
			if (frames_due.size() == 0) begin
				log_fault($sformatf("unexpected frame transaction: status %0d address %02h command %h",
					status, address, command));
			end else begin
				want = frames_due.pop_front();
				if (status !== want.status || address !== want.address ||
						command !== want.command)
					log_fault($sformatf({"frame mismatch: expected status %0d address %02h ",
						"command %h, got status %0d address %02h command %h"}, want.status,
						want.address, want.command, status, address, command));
			end
		end
	end

	initial begin : stimulus
		int unsigned bt_set [6] = '{BIT_TIME_RST, 50, 2000, 50, 2000, 1000};
		int unsigned tol_set [6] = '{TOL_RST, 0, 50, 50, 0, 10};
		int unsigned phase_start;
		int unsigned pick;
		int unsigned len;
		style_t style;
		fault_t flt;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_timing) begin
				drain();
				write_timing(dir_rows[i].bt, dir_rows[i].tol);
			end else begin
				send_frame(dir_rows[i].word, dir_rows[i].len, dir_rows[i].flt, dir_rows[i].pos,
					dir_rows[i].style, dir_rows[i].known, dir_rows[i].res);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 5)
				write_timing($urandom_range(2000, 50), $urandom_range(50));
			else
				write_timing(bt_set[ph], tol_set[ph]);
			send_idle_pct = ph < 2 ? 11 : ph < 4 ? 73 : 0;
			recv_idle_pct = ph < 2 ? 73 : ph < 4 ? 11 : 0;
			phase_start = pulses_sent;
			while (pulses_sent - phase_start < PHASE_PULSES) begin
				pick = $urandom_range(99);
				case ($urandom_range(9))
					0: style = DUR_NOMINAL;
					1: style = DUR_LO_EDGE;
					2: style = DUR_HI_EDGE;
					3, 4: style = DUR_AMBIG;
					default: style = DUR_SPREAD;
				endcase
				if (pick < 60) begin
					send_frame(DATA_W'($urandom), FRAME_LEN, FLT_NONE, 0, style, 1'b0, NO_FRAME);
				end else if (pick < 80) begin
					case ($urandom_range(2))
						0: flt = FLT_LEVEL;
						1: flt = FLT_TIME_LOW;
						default: flt = FLT_TIME_HIGH;
					endcase
					send_frame(DATA_W'($urandom), FRAME_LEN, flt, $urandom_range(FRAME_LEN - 1),
						style, 1'b0, NO_FRAME);
				end else if (pick < 90) begin
					send_frame(DATA_W'($urandom), $urandom_range(40, 1), FLT_NONE, 0, style, 1'b0,
						NO_FRAME);
				end else begin
					// noise: arbitrary levels and lengths, stray end marks
					len = $urandom_range(30, 1);
					for (int unsigned k = 0; k < len; k++)
						send_pulse($urandom_range(1), $urandom_range(1) ?
							$urandom_range(DUR_MAX) : $urandom_range(3 * bit_time),
							k == len - 1 || $urandom_range(15) == 0, 1'b0, NO_FRAME);
				end
			end
		end

		drain();
		if (fault_count == 0)
			$display("[pulse_width_remote_frame_decoder] OK");
		else
			$display("[pulse_width_remote_frame_decoder] ERROR");
		$finish;
	end

endmodule
